// ----- hw/rtl/hsst_pkg.sv -----
package hsst_pkg;

    // Width of the internal wrapping position counter.
    localparam int POSITION_WIDTH = 16;

    localparam int HALL_W  = 3;
    localparam int DELAY_W = 16;
    localparam int POS_OUT_W = 16;

    // Valid Hall codes, in clockwise ring order 1,5,4,6,2,3.
    localparam logic [HALL_W-1:0] HALL_SEC_1 = 3'd1;
    localparam logic [HALL_W-1:0] HALL_SEC_5 = 3'd5;
    localparam logic [HALL_W-1:0] HALL_SEC_4 = 3'd4;
    localparam logic [HALL_W-1:0] HALL_SEC_6 = 3'd6;
    localparam logic [HALL_W-1:0] HALL_SEC_2 = 3'd2;
    localparam logic [HALL_W-1:0] HALL_SEC_3 = 3'd3;

    // Codes with all sensors low or all high are not part of the ring.
    localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_ACW = 1'b1;

    localparam logic [DELAY_W-1:0] INVALID_DELAY_RESET = 16'd10;

    typedef struct packed {
        logic              command;
        logic [HALL_W-1:0] hall_bits;
    } hsst_item_t;

    typedef struct packed {
        logic [HALL_W-1:0]    hall_code;
        logic                 direction;
        logic                 order_fault;
        logic                 invalid_fault;
        logic [POS_OUT_W-1:0] position;
    } hsst_result_t;

    // Code that precedes the given one in clockwise order.
    function automatic logic [HALL_W-1:0] ring_before(input logic [HALL_W-1:0] code);
        logic [HALL_W-1:0] r;
        case (code)
            HALL_SEC_1: r = HALL_SEC_3;
            HALL_SEC_5: r = HALL_SEC_1;
            HALL_SEC_4: r = HALL_SEC_5;
            HALL_SEC_6: r = HALL_SEC_4;
            HALL_SEC_2: r = HALL_SEC_6;
            HALL_SEC_3: r = HALL_SEC_2;
            default:    r = HALL_ALL_LOW;
        endcase
        return r;
    endfunction

    // Code that follows the given one in clockwise order.
    function automatic logic [HALL_W-1:0] ring_after(input logic [HALL_W-1:0] code);
        logic [HALL_W-1:0] r;
        case (code)
            HALL_SEC_1: r = HALL_SEC_5;
            HALL_SEC_5: r = HALL_SEC_4;
            HALL_SEC_4: r = HALL_SEC_6;
            HALL_SEC_6: r = HALL_SEC_2;
            HALL_SEC_2: r = HALL_SEC_3;
            HALL_SEC_3: r = HALL_SEC_1;
            default:    r = HALL_ALL_LOW;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/hall_sensor_sequence_tracker_core.sv -----
// Hall sensor sequence tracker for a brushless motor. Each input beat is either a
// sample tick carrying the three raw Hall sensor bits (A in bit 2, C in bit 0) or a
// clear command that resets the order and invalid faults. A sample that differs
// from the accepted code on two ticks in a row becomes the new accepted code. Steps
// round the clockwise ring 1,5,4,6,2,3 move a wrapping position count down, steps
// the other way move it up, and three like steps in a row confirm the direction.
// A change that is not a single ring step raises the order fault, including the
// first valid code after reset. While the accepted code is 0 or 7 a tick counter
// runs, and once it passes invalid_delay (reset value 10) the sticky invalid fault
// is set. Every input beat yields exactly one result beat showing the state after
// that beat. Throughput is one beat per clock while out_ready stays high; an
// accepted beat is held in the input register, and its result is written into the
// output register once that register is empty or being emptied.
// The input register lets a new beat be taken while a result waits to be read.
// invalid_delay must only be written while no beat is in flight.
module hall_sensor_sequence_tracker_core
    import hsst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [HALL_W-1:0]        hall_bits,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [HALL_W-1:0]        hall_code,
    output logic                     direction,
    output logic                     order_fault,
    output logic                     invalid_fault,
    output logic signed [POS_OUT_W-1:0] position,
    input  logic                     cfg_wr_en,
    input  logic [DELAY_W-1:0]       cfg_wr_data
);

    hsst_item_t         in_item;
    hsst_item_t         held_item;
    logic               held_valid;
    logic               advance;
    hsst_result_t       result_next;
    hsst_result_t       result_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DELAY_W-1:0] delay_reg;

    assign in_item.command   = command;
    assign in_item.hall_bits = hall_bits;

    // A held beat moves on when the output register is empty or being emptied.
    assign advance = held_valid && (!out_valid_reg || out_ready);

    hsst_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    hsst_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (held_item),
        .invalid_delay (delay_reg),
        .result_next   (result_next)
    );

    // The delay register is the only configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= INVALID_DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_reg <= cfg_wr_data;
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hall_code     = result_reg.hall_code;
    assign direction     = result_reg.direction;
    assign order_fault   = result_reg.order_fault;
    assign invalid_fault = result_reg.invalid_fault;
    assign position      = signed'(result_reg.position);

endmodule

// ----- hw/rtl/hsst_in_stage.sv -----
module hsst_in_stage
    import hsst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  hsst_item_t in_item,
    input  logic       advance,
    output logic       held_valid,
    output hsst_item_t held_item
);

    logic       valid_reg;
    logic       valid_next;
    hsst_item_t item_reg;

    // The register frees up in the same cycle that its beat moves on.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- hw/rtl/hsst_tracker.sv -----
module hsst_tracker
    import hsst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  hsst_item_t         item,
    input  logic [DELAY_W-1:0] invalid_delay,
    output hsst_result_t       result_next
);

    logic [HALL_W-1:0]         accepted_reg,  accepted_next;
    logic [HALL_W-1:0]         previous_reg,  previous_next;
    logic [1:0]                debounce_reg,  debounce_next;
    logic [1:0]                fwd_run_reg,   fwd_run_next;
    logic [1:0]                bwd_run_reg,   bwd_run_next;
    logic                      dir_reg,       dir_next;
    logic                      order_reg,     order_next;
    logic                      invalid_reg,   invalid_next;
    logic [DELAY_W-1:0]        timer_reg,     timer_next;
    logic [POSITION_WIDTH-1:0] position_reg,  position_next;
    logic                      code_invalid;
    logic [DELAY_W-1:0]        timer_inc;

    assign timer_inc = timer_reg + 1'b1;

    always_comb
    begin
        accepted_next = accepted_reg;
        previous_next = previous_reg;
        debounce_next = debounce_reg;
        fwd_run_next  = fwd_run_reg;
        bwd_run_next  = bwd_run_reg;
        dir_next      = dir_reg;
        order_next    = order_reg;
        invalid_next  = invalid_reg;
        timer_next    = timer_reg;
        position_next = position_reg;
        code_invalid  = 1'b0;

        if (step)
        begin
            if (item.command == CMD_CLEAR)
            begin
                order_next   = 1'b0;
                invalid_next = 1'b0;
            end
            else
            begin
                // Debounce: a differing sample must be seen on two ticks in a row.
                if (item.hall_bits != accepted_reg)
                begin
                    if (debounce_reg != 2'd0)
                    begin
                        debounce_next = 2'd0;
                        accepted_next = item.hall_bits;
                    end
                    else
                    begin
                        debounce_next = debounce_reg + 2'd1;
                    end
                end
                else
                begin
                    debounce_next = 2'd0;
                end

                code_invalid = (accepted_next == HALL_ALL_LOW) ||
                               (accepted_next == HALL_ALL_HIGH);

                if (!code_invalid && (previous_reg != accepted_next))
                begin
                    if (previous_reg == ring_before(accepted_next))
                    begin
                        bwd_run_next = 2'd0;
                        if (fwd_run_reg > 2'd1)
                        begin
                            fwd_run_next = 2'd0;
                            dir_next     = DIR_CW;
                        end
                        else
                        begin
                            fwd_run_next = fwd_run_reg + 2'd1;
                        end
                        order_next    = 1'b0;
                        position_next = position_reg - 1'b1;
                    end
                    else if (previous_reg == ring_after(accepted_next))
                    begin
                        fwd_run_next = 2'd0;
                        if (bwd_run_reg > 2'd1)
                        begin
                            bwd_run_next = 2'd0;
                            dir_next     = DIR_ACW;
                        end
                        else
                        begin
                            bwd_run_next = bwd_run_reg + 2'd1;
                        end
                        order_next    = 1'b0;
                        position_next = position_reg + 1'b1;
                    end
                    else
                    begin
                        order_next = 1'b1;
                    end
                end
                previous_next = accepted_next;

                if (code_invalid)
                begin
                    if (timer_inc > invalid_delay)
                    begin
                        invalid_next = 1'b1;
                        timer_next   = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                else
                begin
                    timer_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= '0;
            previous_reg <= '0;
            debounce_reg <= '0;
            fwd_run_reg  <= '0;
            bwd_run_reg  <= '0;
            dir_reg      <= 1'b0;
            order_reg    <= 1'b0;
            invalid_reg  <= 1'b0;
            timer_reg    <= '0;
            position_reg <= '0;
        end
        else
        begin
            accepted_reg <= accepted_next;
            previous_reg <= previous_next;
            debounce_reg <= debounce_next;
            fwd_run_reg  <= fwd_run_next;
            bwd_run_reg  <= bwd_run_next;
            dir_reg      <= dir_next;
            order_reg    <= order_next;
            invalid_reg  <= invalid_next;
            timer_reg    <= timer_next;
            position_reg <= position_next;
        end
    end

    assign result_next.hall_code     = accepted_next;
    assign result_next.direction     = dir_next;
    assign result_next.order_fault   = order_next;
    assign result_next.invalid_fault = invalid_next;
    assign result_next.position      = POS_OUT_W'(position_next);

endmodule

// ----- hw/rtl/hsst_checker.sv -----
module hsst_checker
    import hsst_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [HALL_W-1:0]           hall_code,
    input logic                        direction,
    input logic                        order_fault,
    input logic                        invalid_fault,
    input logic signed [POS_OUT_W-1:0] position
);

    logic                        seen_reg;
    logic signed [POS_OUT_W-1:0] last_pos_reg;
    logic                        last_dir_reg;
    logic signed [POS_OUT_W-1:0] pos_delta;
    logic                        out_beat;

    assign out_beat  = out_valid && out_ready;
    assign pos_delta = position - last_pos_reg;

    // Track the previous delivered beat; before the first, compare against reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_pos_reg <= '0;
            last_dir_reg <= DIR_CW;
        end
        else if (out_beat)
        begin
            seen_reg     <= 1'b1;
            last_pos_reg <= position;
            last_dir_reg <= direction;
        end
    end

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(hall_code)
            && $stable(direction) && $stable(order_fault) && $stable(invalid_fault))
        else $error("result beat changed while stalled");

    // Position moves by at most one step per beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (pos_delta == 0) || (pos_delta == 1) || (pos_delta == -1))
        else $error("position jumped by more than one step");

    // A direction change only comes with a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && (direction != last_dir_reg) |-> (position != last_pos_reg))
        else $error("direction changed without a step");

    // No step is counted while the accepted code is off the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && ((hall_code == HALL_ALL_LOW) || (hall_code == HALL_ALL_HIGH))
            |-> (position == last_pos_reg))
        else $error("position moved on an invalid code");

    // The first result after reset cannot yet show a confirmed anticlockwise turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && !seen_reg |-> (direction == DIR_CW) || (position != 0))
        else $error("first result shows a direction change without a step");

endmodule

bind hall_sensor_sequence_tracker_core hsst_checker u_hsst_checker (.*);
